// ===== sv/bpd_pkg.sv =====
// ============================================================================
// bpd_pkg
// Types, status codes and command tables for the boot packet deframer.
// ============================================================================
`default_nettype none

package bpd_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned WORD_SLOTS = 8;
    localparam int unsigned SLOT_W     = $clog2(WORD_SLOTS);
    localparam int unsigned HDR_BYTES  = 8;
    localparam int unsigned STORE_BYTES = WORD_SLOTS * 4;
    localparam int unsigned PAY_WORDS  = 6;

    localparam logic [WORD_W-1:0] CMD_FIRST   = 32'h0000_0001;
    localparam logic [WORD_W-1:0] CMD_LAST    = 32'h0000_0013;
    localparam logic [WORD_W-1:0] CMD_CHIP_ID = 32'h0000_000A;
    localparam logic [WORD_W-1:0] V3_MIN_LEN  = 32'd40;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_UNDER_HDR = 3'd1,
        STAT_TRUNC     = 3'd2,
        STAT_BELOW_MIN = 3'd3,
        STAT_UNKNOWN   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] command;
        logic [WORD_W-1:0] declared_length;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic [WORD_W-1:0] word_e;
        logic [WORD_W-1:0] word_f;
        logic              v3_flag;
    } out_beat_t;

    // minimum declared length per known command, 0 for unknown
    function automatic logic [5:0] min_len(input logic [4:0] cmd);
        logic [5:0] r;
        unique case (cmd)
            5'h01, 5'h02:                             r = 6'd48;
            5'h03, 5'h11:                             r = 6'd20;
            5'h04, 5'h09, 5'h0A, 5'h0E, 5'h0F,
            5'h10, 5'h12:                             r = 6'd16;
            5'h05, 5'h07, 5'h08, 5'h0B, 5'h13:        r = 6'd8;
            5'h06, 5'h0C, 5'h0D:                      r = 6'd12;
            default:                                  r = 6'd0;
        endcase
        return r;
    endfunction

    // payload words used per known command
    function automatic logic [2:0] words_used(input logic [4:0] cmd);
        logic [2:0] r;
        unique case (cmd)
            5'h01, 5'h02:                             r = 3'd4;
            5'h03, 5'h11:                             r = 3'd3;
            5'h04, 5'h09, 5'h0A, 5'h0E, 5'h0F,
            5'h10, 5'h12:                             r = 3'd2;
            5'h06, 5'h0C, 5'h0D:                      r = 3'd1;
            default:                                  r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/boot_packet_deframer_unit.sv =====
// ============================================================================
// boot_packet_deframer_unit
// Length-prefixed boot packet parser: one byte per beat, one result per buffer.
// ============================================================================
// Usage:
//   s_ channel carries one received byte per beat plus a flag on the buffer's
//   last byte. Bytes 0..7 hold the little-endian command and length words,
//   bytes 8..31 six payload words; later bytes are only counted.
//   m_ channel carries one result per buffer: status, header words and the
//   payload words the command uses (others zero), plus the chip-id V3 flag.
//   The result is registered: it is valid in the cycle after its last byte is accepted.
//   Throughput: one byte per cycle; the byte counter and header store update
//   in the accept cycle and the checks feed the single output register.
//   A stalled result blocks s_ready only while the output register is full
//   and m_ready is low; a new byte is taken in the same cycle the result
//   leaves. Reset clears the byte counter and the output valid; after each
//   last byte the counter returns to zero for the next buffer.
// ============================================================================
`default_nettype none

module boot_packet_deframer_unit
    import bpd_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  wire       m_ready,
    output out_beat_t m_payload
);

    logic [WORD_W-1:0] byte_count_reg, byte_count_next;
    logic [WORD_W-1:0] header_words_reg  [WORD_SLOTS];
    logic [WORD_W-1:0] header_words_next [WORD_SLOTS];
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_payload_reg, m_payload_next;

    logic              accept;
    logic              cmd_known;
    logic [5:0]        minlen;
    logic [2:0]        nwords;
    logic [WORD_W-1:0] cmd, len;
    logic              v3;
    logic [WORD_W-1:0] pay [PAY_WORDS];

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // counter and header store
    always_comb begin
        byte_count_next = byte_count_reg;
        for (int i = 0; i < WORD_SLOTS; i++) begin
            header_words_next[i] = header_words_reg[i];
        end
        if (accept) begin
            if (byte_count_reg < WORD_W'(STORE_BYTES)) begin
                for (int i = 0; i < WORD_SLOTS; i++) begin
                    if (byte_count_reg[SLOT_W+1:2] == SLOT_W'(i)) begin
                        for (int j = 0; j < 4; j++) begin
                            if (byte_count_reg[1:0] == 2'(j)) begin
                                header_words_next[i][8*j +: 8] = s_payload.data_byte;
                            end
                        end
                    end
                end
            end
            if (byte_count_reg != '1) begin
                byte_count_next = byte_count_reg + WORD_W'(1);
            end
        end
    end

    // packet checks on the state including the current byte
    always_comb begin
        cmd       = header_words_next[0];
        len       = header_words_next[1];
        cmd_known = (cmd >= CMD_FIRST) && (cmd <= CMD_LAST);
        minlen    = cmd_known ? min_len(cmd[4:0]) : 6'd0;
        nwords    = cmd_known ? words_used(cmd[4:0]) : 3'd0;
        v3        = (cmd == CMD_CHIP_ID) && (len >= V3_MIN_LEN);
        if (v3) begin
            nwords = 3'(PAY_WORDS);
        end
        for (int k = 0; k < PAY_WORDS; k++) begin
            pay[k] = '0;
            if ((3'(k) < nwords) && (byte_count_next >= WORD_W'(4 * k + 12))) begin
                pay[k] = header_words_next[k + 2];
            end
        end

        m_payload_next = '0;
        priority if (byte_count_next < WORD_W'(HDR_BYTES)) begin
            m_payload_next.status = STAT_UNDER_HDR;
        end else begin
            m_payload_next.command         = cmd;
            m_payload_next.declared_length = len;
            priority if (byte_count_next < len) begin
                m_payload_next.status = STAT_TRUNC;
            end else if (len < WORD_W'(minlen)) begin
                m_payload_next.status = STAT_BELOW_MIN;
            end else if (!cmd_known) begin
                m_payload_next.status = STAT_UNKNOWN;
            end else begin
                m_payload_next.status  = STAT_OK;
                m_payload_next.word_a  = pay[0];
                m_payload_next.word_b  = pay[1];
                m_payload_next.word_c  = pay[2];
                m_payload_next.word_d  = pay[3];
                m_payload_next.word_e  = pay[4];
                m_payload_next.word_f  = pay[5];
                m_payload_next.v3_flag = v3;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept && s_payload.last_byte) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            byte_count_reg <= (accept && s_payload.last_byte) ? '0 : byte_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WORD_SLOTS; i++) begin
            header_words_reg[i] <= header_words_next[i];
        end
        if (accept && s_payload.last_byte) begin
            m_payload_reg <= m_payload_next;
        end
    end

    // checks
    a_count_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_payload.last_byte |=> byte_count_reg == '0)
        else $error("byte count not cleared after last beat");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_payload.last_byte |=> m_valid)
        else $error("no result after last beat");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(accept && s_payload.last_byte))
        else $error("result without a last beat");

    a_fail_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status != STAT_OK) |->
            (m_payload.word_a == '0) && (m_payload.word_f == '0) && !m_payload.v3_flag)
        else $error("payload on failed packet");

    a_v3_chip_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.v3_flag |->
            (m_payload.command == CMD_CHIP_ID) && (m_payload.status == STAT_OK))
        else $error("v3 flag on non chip-id packet");

endmodule

`default_nettype wire

// ===== dv/boot_packet_deframer_unit_tb.sv =====
// ============================================================================
// boot_packet_deframer_unit_tb
// Self-checking bench for the boot packet deframer. Buffers are fed one byte
// per beat: a directed set over every command code and each status, then
// random buffers, mostly well formed with random content and the rest short,
// truncated, below minimum or unknown. A local model predicts one result per
// buffer and every result beat is checked field by field, in order.
// ============================================================================
`timescale 1ns / 100ps

module boot_packet_deframer_unit_tb;
    import bpd_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_payload;

    boot_packet_deframer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // stimulus and model state
    in_beat_t    byte_q [$];
    out_beat_t   frame_q [$];
    logic [31:0] rx_count = '0;
    logic [31:0] rx_words [WORD_SLOTS];
    logic        in_fired = 1'b0;
    logic        calm = 1'b0;
    int          queued_bytes = 0;
    int          cycle_cnt = 0;
    int          byte_cnt = 0;
    int          frame_cnt = 0;
    int          errors = 0;
    int          stat_seen [5];
    out_beat_t   want;
    logic        bad;

    // Model: absorb one byte, push the frame verdict on the last byte.
    function automatic void deframe_byte(input in_beat_t beat);
        out_beat_t   res;
        logic [31:0] cmd;
        logic [31:0] len;
        logic [31:0] need;
        logic [31:0] pay [PAY_WORDS];
        logic        known;
        int          nw;
        if (rx_count < STORE_BYTES)
            rx_words[rx_count[4:2]][rx_count[1:0]*8 +: 8] = beat.data_byte;
        if (rx_count != '1)
            rx_count++;
        if (!beat.last_byte)
            return;
        res = '0;
        if (rx_count < HDR_BYTES) begin
            res.status = STAT_UNDER_HDR;
        end else begin
            cmd   = rx_words[0];
            len   = rx_words[1];
            res.command = cmd;
            res.declared_length = len;
            known = (cmd >= CMD_FIRST) && (cmd <= CMD_LAST);
            need  = 0;
            nw    = 0;
            if (known) begin
                case (cmd[4:0])
                    5'h01, 5'h02: begin need = 48; nw = 4; end
                    5'h03, 5'h11: begin need = 20; nw = 3; end
                    5'h04, 5'h09, 5'h0A, 5'h0E, 5'h0F, 5'h10, 5'h12: begin
                        need = 16; nw = 2;
                    end
                    5'h06, 5'h0C, 5'h0D: begin need = 12; nw = 1; end
                    default: begin need = 8; nw = 0; end
                endcase
            end
            if (rx_count < len) begin
                res.status = STAT_TRUNC;
            end else if (len < need) begin
                res.status = STAT_BELOW_MIN;
            end else if (!known) begin
                res.status = STAT_UNKNOWN;
            end else begin
                res.status = STAT_OK;
                if (cmd == CMD_CHIP_ID && len >= V3_MIN_LEN) begin
                    res.v3_flag = 1'b1;
                    nw = PAY_WORDS;
                end
                for (int k = 0; k < PAY_WORDS; k++)
                    pay[k] = (k < nw && rx_count >= 4 * (k + 3)) ? rx_words[k + 2] : '0;
                res.word_a = pay[0];
                res.word_b = pay[1];
                res.word_c = pay[2];
                res.word_d = pay[3];
                res.word_e = pay[4];
                res.word_f = pay[5];
            end
        end
        frame_q.push_back(res);
        rx_count = '0;
        for (int k = 0; k < WORD_SLOTS; k++)
            rx_words[k] = '0;
    endfunction

    // queue one buffer: command word, length word, then random payload
    task automatic add_buffer(input logic [31:0] cmd, input logic [31:0] len,
                              input int nbytes);
        in_beat_t b;
        for (int i = 0; i < nbytes; i++) begin
            if (i < 4)
                b.data_byte = cmd[8*i +: 8];
            else if (i < 8)
                b.data_byte = len[8*(i-4) +: 8];
            else
                b.data_byte = 8'($urandom_range(0, 255));
            b.last_byte = (i == nbytes - 1);
            byte_q.push_back(b);
        end
        queued_bytes += nbytes;
    endtask

    task automatic add_random(input int n_target);
        int          stop_at;
        int          kind;
        int          nbytes;
        logic [31:0] cmd;
        logic [31:0] len;
        stop_at = queued_bytes + n_target;
        while (queued_bytes < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                cmd = ($urandom_range(0, 3) == 0) ? CMD_CHIP_ID
                                                  : $urandom_range(CMD_FIRST, CMD_LAST);
                len = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 52)
                                                  : $urandom_range(8, 24);
                nbytes = len + $urandom_range(0, 3);
            end else if (kind == 6) begin
                cmd = $urandom_range(CMD_FIRST, CMD_LAST);
                len = $urandom_range(0, 52);
                nbytes = $urandom_range(HDR_BYTES, 56);
            end else if (kind == 7) begin
                cmd = $urandom_range(0, 1) ? $urandom : '0;
                if (cmd >= CMD_FIRST && cmd <= CMD_LAST)
                    cmd = CMD_LAST + 1;
                len = $urandom_range(0, 40);
                nbytes = $urandom_range(HDR_BYTES, 44);
            end else if (kind == 8) begin
                cmd = $urandom;
                len = $urandom;
                nbytes = $urandom_range(1, HDR_BYTES - 1);
            end else begin
                cmd = $urandom;
                len = $urandom;
                nbytes = $urandom_range(1, 40);
            end
            add_buffer(cmd, len, nbytes);
        end
    endtask

    // sampled on the rising edge, where driver outputs and queues are settled
    task automatic wait_drained();
        while (byte_q.size() != 0 || s_valid || frame_q.size() != 0)
            @(posedge aclk);
    endtask

    // driver: inputs move on the falling edge
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 20);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fired) begin
            if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                s_payload <= byte_q.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: check result beats, then feed accepted bytes to the model
    always @(posedge aclk) begin
        cycle_cnt++;
        in_fired <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            rx_count = '0;
            for (int k = 0; k < WORD_SLOTS; k++)
                rx_words[k] = '0;
        end else begin
            if (m_valid && m_ready) begin
                frame_cnt++;
                if (frame_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("cycle %0d: result beat with nothing expected", cycle_cnt);
                end else begin
                    want = frame_q.pop_front();
                    stat_seen[want.status]++;
                    bad = (m_payload.status          !== want.status)
                       || (m_payload.command         !== want.command)
                       || (m_payload.declared_length !== want.declared_length)
                       || (m_payload.word_a          !== want.word_a)
                       || (m_payload.word_b          !== want.word_b)
                       || (m_payload.word_c          !== want.word_c)
                       || (m_payload.word_d          !== want.word_d)
                       || (m_payload.word_e          !== want.word_e)
                       || (m_payload.word_f          !== want.word_f)
                       || (m_payload.v3_flag         !== want.v3_flag);
                    if (bad) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("cycle %0d: result %0d mismatch", cycle_cnt, frame_cnt);
                            $display("  exp st=%0d cmd=%h len=%h w=%h %h %h %h %h %h v3=%b",
                                     want.status, want.command, want.declared_length,
                                     want.word_a, want.word_b, want.word_c, want.word_d,
                                     want.word_e, want.word_f, want.v3_flag);
                            $display("  got st=%0d cmd=%h len=%h w=%h %h %h %h %h %h v3=%b",
                                     m_payload.status, m_payload.command,
                                     m_payload.declared_length, m_payload.word_a,
                                     m_payload.word_b, m_payload.word_c, m_payload.word_d,
                                     m_payload.word_e, m_payload.word_f, m_payload.v3_flag);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                byte_cnt++;
                deframe_byte(s_payload);
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt, frame_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] c;
        for (int k = 0; k < 5; k++)
            stat_seen[k] = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: short buffers, every command code, each status
        add_buffer($urandom, $urandom, 1);
        add_buffer(CMD_CHIP_ID, V3_MIN_LEN, HDR_BYTES - 1);
        add_buffer(CMD_LAST, HDR_BYTES, HDR_BYTES);
        for (c = 0; c <= CMD_LAST + 1; c++)
            add_buffer(c, 20, 20);
        add_buffer(CMD_FIRST, 48, 48);
        add_buffer(CMD_FIRST + 1, 52, 55);
        add_buffer(CMD_FIRST, 47, 47);
        add_buffer(CMD_FIRST, '1, HDR_BYTES);
        add_buffer('1, '1, HDR_BYTES);
        add_buffer('1, '0, 12);
        add_buffer(CMD_CHIP_ID, V3_MIN_LEN - 1, V3_MIN_LEN - 1);
        add_buffer(CMD_CHIP_ID, V3_MIN_LEN, V3_MIN_LEN);
        wait_drained();

        // random: idling, then a stretch with none, then idling again
        add_random(170);
        wait_drained();
        calm = 1'b1;
        add_random(170);
        wait_drained();
        calm = 1'b0;
        add_random(170);
        wait_drained();
        repeat (4) @(posedge aclk);

        $display("%0d bytes in, %0d results: ok %0d, under header %0d, truncated %0d,",
                 byte_cnt, frame_cnt, stat_seen[STAT_OK], stat_seen[STAT_UNDER_HDR],
                 stat_seen[STAT_TRUNC]);
        $display("below minimum %0d, unknown command %0d, mismatches %0d",
                 stat_seen[STAT_BELOW_MIN], stat_seen[STAT_UNKNOWN], errors);
        if (errors == 0 && frame_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bpd_pkg.sv
sv/boot_packet_deframer_unit.sv
dv/boot_packet_deframer_unit_tb.sv
